// File: hdl/temp_humidity_compensation_unit_macros.svh
// Assertion macros for the compensation unit.
`ifndef TEMP_HUMIDITY_COMPENSATION_UNIT_MACROS_SVH
`define TEMP_HUMIDITY_COMPENSATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define THC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define THC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define THC_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define THC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/thc_pkg.sv
`timescale 1ns / 1ps
package thc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned RawTempW = 20;
  localparam int unsigned RawHumW  = 16;
  localparam int unsigned HumOutW  = 17;
  localparam int unsigned Latency  = 10;

  localparam logic [CfgIdxW-1:0] RegCalT1   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCalT2   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCalT3   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCalH1   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCalH2   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCalH3   = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCalH4H5 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegCalH6   = 3'd7;

  localparam logic [31:0] FineOffset = 32'd76800;
  localparam logic [31:0] HumMax     = 32'd419430400;
  localparam logic [31:0] RoundX     = 32'd16384;
  localparam logic [31:0] BiasY      = 32'd2097152;
  localparam logic [31:0] BiasH3     = 32'd32768;
  localparam logic [31:0] RoundY     = 32'd8192;
  localparam logic [31:0] RoundTemp  = 32'd128;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [23:0] h4_h5;
    logic [7:0]  h6;
  } thc_cal_t;

  // Arithmetic right shift of a 32-bit two's complement word.
  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

endpackage

// File: hdl/temp_humidity_compensation_unit.sv
`timescale 1ns / 1ps
// A sample pair accepted by start gives its result strobe once it has passed every register stage.
// Throughput: one sample pair per cycle; busy is never raised and each result is shown once.
// Ten register stages, each at most one multiply deep, set the latency.
// Reset clears the pipeline valid bits and sets every trimming word to zero.
// The receiver cannot stall, so results are never held back.
module temp_humidity_compensation_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [thc_pkg::RawTempW-1:0] raw_temperature_i,
  input  logic [thc_pkg::RawHumW-1:0]  raw_humidity_i,
  output logic                         result_valid_o,
  output logic [31:0]                  temperature_centi_o,
  output logic [31:0]                  fine_temperature_o,
  output logic [thc_pkg::HumOutW-1:0]  humidity_q10_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [thc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [thc_pkg::CfgDataW-1:0] cfg_data_i
);
  import thc_pkg::*;

  thc_cal_t cal_q;
  logic     accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start & ~busy;

  // Each trimming word keeps only the bits of its own width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegCalT1:   cal_q.t1    <= cfg_data_i[15:0];
        RegCalT2:   cal_q.t2    <= cfg_data_i[15:0];
        RegCalT3:   cal_q.t3    <= cfg_data_i[15:0];
        RegCalH1:   cal_q.h1    <= cfg_data_i[7:0];
        RegCalH2:   cal_q.h2    <= cfg_data_i[15:0];
        RegCalH3:   cal_q.h3    <= cfg_data_i[7:0];
        RegCalH4H5: cal_q.h4_h5 <= cfg_data_i;
        RegCalH6:   cal_q.h6    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  thc_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (accept),
    .raw_temperature_i   (raw_temperature_i),
    .raw_humidity_i      (raw_humidity_i),
    .cal_i               (cal_q),
    .out_valid_o         (result_valid_o),
    .temperature_centi_o (temperature_centi_o),
    .fine_temperature_o  (fine_temperature_o),
    .humidity_q10_o      (humidity_q10_o)
  );

endmodule

// File: hdl/thc_datapath.sv
`timescale 1ns / 1ps
`include "temp_humidity_compensation_unit_macros.svh"
module thc_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [thc_pkg::RawTempW-1:0] raw_temperature_i,
  input  logic [thc_pkg::RawHumW-1:0]  raw_humidity_i,
  input  thc_pkg::thc_cal_t            cal_i,
  output logic                         out_valid_o,
  output logic [31:0]                  temperature_centi_o,
  output logic [31:0]                  fine_temperature_o,
  output logic [thc_pkg::HumOutW-1:0]  humidity_q10_o
);
  import thc_pkg::*;

  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [Latency-1:0] valid_q;

  assign t1 = {16'd0, cal_i.t1};
  assign t2 = {{16{cal_i.t2[15]}}, cal_i.t2};
  assign t3 = {{16{cal_i.t3[15]}}, cal_i.t3};
  assign h1 = {24'd0, cal_i.h1};
  assign h2 = {{16{cal_i.h2[15]}}, cal_i.h2};
  assign h3 = {24'd0, cal_i.h3};
  assign h4 = {{20{cal_i.h4_h5[23]}}, cal_i.h4_h5[23:12]};
  assign h5 = {{20{cal_i.h4_h5[11]}}, cal_i.h4_h5[11:0]};
  assign h6 = {{24{cal_i.h6[7]}}, cal_i.h6};

  // Stage 1: linear and quadratic temperature products.
  logic [31:0] lin_d, dif_d, ta_d, dd_d;
  logic [31:0] ta_q, dd_q;
  logic [RawHumW-1:0] hum1_q;
  assign lin_d = {15'd0, raw_temperature_i[19:3]} - {15'd0, cal_i.t1, 1'b0};
  assign dif_d = {16'd0, raw_temperature_i[19:4]} - t1;
  assign ta_d  = lin_d * t2;
  assign dd_d  = dif_d * dif_d;

  // Stage 2: quadratic term scaled by T3.
  logic [31:0] a_d, q_d, a_q, q_q;
  logic [RawHumW-1:0] hum2_q;
  assign a_d = asr(ta_q, 11);
  assign q_d = asr(dd_q, 12) * t3;

  // Stage 3: fine temperature.
  logic [31:0] fine_d, fine3_q;
  logic [RawHumW-1:0] hum3_q;
  assign fine_d = a_q + asr(q_q, 14);

  // Stage 4: products of the offset fine temperature.
  logic [31:0] v_d, tpre_d, h5v_d, vh6_d, vh3_d;
  logic [31:0] fine4_q, tpre_q, h5v_q, vh6_q, vh3_q;
  logic [RawHumW-1:0] hum4_q;
  assign v_d    = fine3_q - FineOffset;
  assign tpre_d = (fine3_q << 2) + fine3_q + RoundTemp;
  assign h5v_d  = h5 * v_d;
  assign vh6_d  = v_d * h6;
  assign vh3_d  = v_d * h3;

  // Stage 5: humidity offset term and the first gain product.
  logic [31:0] temp_d, x_d, y0_d;
  logic [31:0] temp5_q, fine5_q, x5_q, y0_q;
  assign temp_d = asr(tpre_q, 8);
  assign x_d = asr(({16'd0, hum4_q} << 14) - (h4 << 20) - h5v_q + RoundX, 15);
  assign y0_d = asr(vh6_q, 10) * (asr(vh3_q, 11) + BiasH3);

  // Stage 6: overall gain H2.
  logic [31:0] y1_d, yp_d;
  logic [31:0] temp6_q, fine6_q, x6_q, yp_q;
  assign y1_d = asr(y0_q, 10) + BiasY;
  assign yp_d = y1_d * h2 + RoundY;

  // Stage 7: raw humidity product.
  logic [31:0] hv_d;
  logic [31:0] temp7_q, fine7_q, hv7_q;
  assign hv_d = x6_q * asr(yp_q, 14);

  // Stage 8: square of the scaled humidity.
  logic [31:0] ss_d;
  logic [31:0] temp8_q, fine8_q, hv8_q, ss_q;
  assign ss_d = asr(hv7_q, 15) * asr(hv7_q, 15);

  // Stage 9: quadratic correction by H1.
  logic [31:0] w_d;
  logic [31:0] temp9_q, fine9_q, hv9_q, w_q;
  assign w_d = asr(ss_q, 7) * h1;

  // Stage 10: subtract, clamp and scale down.
  logic [31:0] r_d, clamp_d;
  logic [31:0] temp10_q, fine10_q;
  logic [HumOutW-1:0] hum10_q;
  assign r_d = hv9_q - asr(w_q, 4);
  always_comb begin
    if (r_d[31]) begin
      clamp_d = '0;
    end else if (r_d > HumMax) begin
      clamp_d = HumMax;
    end else begin
      clamp_d = r_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Latency-2:0], in_valid_i};
    end
  end

  // Payload registers; each stage loads only when a word enters it.
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      ta_q   <= ta_d;
      dd_q   <= dd_d;
      hum1_q <= raw_humidity_i;
    end
    if (valid_q[0]) begin
      a_q    <= a_d;
      q_q    <= q_d;
      hum2_q <= hum1_q;
    end
    if (valid_q[1]) begin
      fine3_q <= fine_d;
      hum3_q  <= hum2_q;
    end
    if (valid_q[2]) begin
      fine4_q <= fine3_q;
      tpre_q  <= tpre_d;
      h5v_q   <= h5v_d;
      vh6_q   <= vh6_d;
      vh3_q   <= vh3_d;
      hum4_q  <= hum3_q;
    end
    if (valid_q[3]) begin
      temp5_q <= temp_d;
      fine5_q <= fine4_q;
      x5_q    <= x_d;
      y0_q    <= y0_d;
    end
    if (valid_q[4]) begin
      temp6_q <= temp5_q;
      fine6_q <= fine5_q;
      x6_q    <= x5_q;
      yp_q    <= yp_d;
    end
    if (valid_q[5]) begin
      temp7_q <= temp6_q;
      fine7_q <= fine6_q;
      hv7_q   <= hv_d;
    end
    if (valid_q[6]) begin
      temp8_q <= temp7_q;
      fine8_q <= fine7_q;
      hv8_q   <= hv7_q;
      ss_q    <= ss_d;
    end
    if (valid_q[7]) begin
      temp9_q <= temp8_q;
      fine9_q <= fine8_q;
      hv9_q   <= hv8_q;
      w_q     <= w_d;
    end
    if (valid_q[8]) begin
      temp10_q <= temp9_q;
      fine10_q <= fine9_q;
      hum10_q  <= clamp_d[28:12];
    end
  end

  assign out_valid_o         = valid_q[Latency-1];
  assign temperature_centi_o = temp10_q;
  assign fine_temperature_o  = fine10_q;
  assign humidity_q10_o      = hum10_q;

  // Every word leaving the pipeline was accepted at its input and tracked by the valid shift register.
  `THC_ASSERT_SAME(a_latency, clk_i, rst_ni, out_valid_o, $past(in_valid_i, Latency))
  `THC_ASSERT_SAME(a_hum_range, clk_i, rst_ni, out_valid_o, humidity_q10_o <= 17'd102400)
  `THC_ASSERT_NEXT(a_hum_neg_clamp, clk_i, rst_ni, valid_q[8] && r_d[31], humidity_q10_o == '0)
  `THC_ASSERT_NEXT(a_fine_carried, clk_i, rst_ni, valid_q[8], fine_temperature_o == $past(fine9_q))

endmodule

// File: tb/sv/thc_checker.sv
`timescale 1ns / 1ps
module thc_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [thc_pkg::RawTempW-1:0] raw_temperature_i,
  input  logic [thc_pkg::RawHumW-1:0]  raw_humidity_i,
  input  logic                         result_valid_i,
  input  logic [31:0]                  temperature_centi_i,
  input  logic [31:0]                  fine_temperature_i,
  input  logic [thc_pkg::HumOutW-1:0]  humidity_q10_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [thc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [thc_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           fail_count_o,
  output int                           outstanding_o,
  output int                           readings_o,
  output int                           limit_hits_o
);

  localparam logic [31:0] FineBase     = 32'd76800;
  localparam logic [31:0] HumCeiling   = 32'd419430400;
  localparam logic [31:0] HumRound     = 32'd16384;
  localparam logic [31:0] GainBias     = 32'd2097152;
  localparam logic [31:0] H3Bias       = 32'd32768;
  localparam logic [31:0] GainRound    = 32'd8192;
  localparam logic [31:0] TempRound    = 32'd128;
  localparam logic [thc_pkg::HumOutW-1:0] HumFullScale = 17'd102400;

  typedef struct packed {
    logic [31:0]                 temp_centi;
    logic [31:0]                 fine;
    logic [thc_pkg::HumOutW-1:0] hum_q10;
  } reading_t;

  reading_t           expected_readings [$];
  thc_pkg::thc_cal_t  cal;

  // Every right shift below sits in a statement of its own so that it stays arithmetic.
  function automatic reading_t compensate(input thc_pkg::thc_cal_t c,
                                          input logic [19:0] adc_t,
                                          input logic [15:0] adc_h);
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [31:0] a, b, d, fine, tc, v, x, y, p, q, s;
    reading_t    r;
    t1 = {16'b0, c.t1};
    t2 = {{16{c.t2[15]}}, c.t2};
    t3 = {{16{c.t3[15]}}, c.t3};
    h1 = {24'b0, c.h1};
    h2 = {{16{c.h2[15]}}, c.h2};
    h3 = {24'b0, c.h3};
    h4 = {{20{c.h4_h5[23]}}, c.h4_h5[23:12]};
    h5 = {{20{c.h4_h5[11]}}, c.h4_h5[11:0]};
    h6 = {{24{c.h6[7]}}, c.h6};

    a = {15'b0, adc_t[19:3]} - (t1 << 1);
    a = a * t2;
    a = $signed(a) >>> 11;
    d = {16'b0, adc_t[19:4]} - t1;
    b = d * d;
    b = $signed(b) >>> 12;
    b = b * t3;
    b = $signed(b) >>> 14;
    fine = a + b;
    tc = fine * 32'd5 + TempRound;
    tc = $signed(tc) >>> 8;

    v = fine - FineBase;
    x = ({16'b0, adc_h} << 14) - (h4 << 20) - (h5 * v) + HumRound;
    x = $signed(x) >>> 15;
    p = v * h6;
    p = $signed(p) >>> 10;
    q = v * h3;
    q = $signed(q) >>> 11;
    q = q + H3Bias;
    y = p * q;
    y = $signed(y) >>> 10;
    y = y + GainBias;
    y = y * h2 + GainRound;
    y = $signed(y) >>> 14;
    v = x * y;
    s = $signed(v) >>> 15;
    q = s * s;
    q = $signed(q) >>> 7;
    q = q * h1;
    q = $signed(q) >>> 4;
    v = v - q;
    if (v[31]) begin
      v = '0;
    end else if (v > HumCeiling) begin
      v = HumCeiling;
    end

    r.temp_centi = tc;
    r.fine       = fine;
    r.hum_q10    = v[28:12];
    return r;
  endfunction

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reading_t want;
    if (!rst_ni) begin
      expected_readings.delete();
      cal           = '0;
      fail_count_o  = 0;
      outstanding_o = 0;
      readings_o    = 0;
      limit_hits_o  = 0;
    end else begin
      if (result_valid_i) begin
        if (expected_readings.size() == 0) begin
          report($sformatf("result word with no sample pending (temp %0d)",
                           $signed(temperature_centi_i)));
        end else begin
          want = expected_readings.pop_front();
          readings_o++;
          if (temperature_centi_i !== want.temp_centi)
            report($sformatf("temperature expected %0d got %0d",
                             $signed(want.temp_centi), $signed(temperature_centi_i)));
          if (fine_temperature_i !== want.fine)
            report($sformatf("fine temperature expected %0d got %0d",
                             $signed(want.fine), $signed(fine_temperature_i)));
          if (humidity_q10_i !== want.hum_q10)
            report($sformatf("humidity expected %0d got %0d",
                             want.hum_q10, humidity_q10_i));
          if (want.hum_q10 == '0 || want.hum_q10 == HumFullScale)
            limit_hits_o++;
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          thc_pkg::RegCalT1:   cal.t1    = cfg_data_i[15:0];
          thc_pkg::RegCalT2:   cal.t2    = cfg_data_i[15:0];
          thc_pkg::RegCalT3:   cal.t3    = cfg_data_i[15:0];
          thc_pkg::RegCalH1:   cal.h1    = cfg_data_i[7:0];
          thc_pkg::RegCalH2:   cal.h2    = cfg_data_i[15:0];
          thc_pkg::RegCalH3:   cal.h3    = cfg_data_i[7:0];
          thc_pkg::RegCalH4H5: cal.h4_h5 = cfg_data_i[23:0];
          thc_pkg::RegCalH6:   cal.h6    = cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i)
        expected_readings.push_back(compensate(cal, raw_temperature_i, raw_humidity_i));

      outstanding_o = expected_readings.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int WatchdogLimit = 1000;
  localparam int FlushCycles   = thc_pkg::Latency + 6;

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [thc_pkg::RawTempW-1:0] raw_temperature_i;
  logic [thc_pkg::RawHumW-1:0]  raw_humidity_i;
  logic                         result_valid_o;
  logic [31:0]                  temperature_centi_o;
  logic [31:0]                  fine_temperature_o;
  logic [thc_pkg::HumOutW-1:0]  humidity_q10_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [thc_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [thc_pkg::CfgDataW-1:0] cfg_data_i;

  int fail_count;
  int outstanding;
  int readings;
  int limit_hits;
  int pairs_sent;
  int cal_sets;
  int idle_cycles = 0;
  bit no_idle;

  always #2 clk_i = ~clk_i;

  temp_humidity_compensation_unit DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .raw_temperature_i   (raw_temperature_i),
    .raw_humidity_i      (raw_humidity_i),
    .result_valid_o      (result_valid_o),
    .temperature_centi_o (temperature_centi_o),
    .fine_temperature_o  (fine_temperature_o),
    .humidity_q10_o      (humidity_q10_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  thc_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start),
    .busy_i              (busy),
    .raw_temperature_i   (raw_temperature_i),
    .raw_humidity_i      (raw_humidity_i),
    .result_valid_i      (result_valid_o),
    .temperature_centi_i (temperature_centi_o),
    .fine_temperature_i  (fine_temperature_o),
    .humidity_q10_i      (humidity_q10_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_i         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .fail_count_o        (fail_count),
    .outstanding_o       (outstanding),
    .readings_o          (readings),
    .limit_hits_o        (limit_hits)
  );

  // The run is stopped if no word moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("temp_humidity_compensation_unit: mismatch");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_sample(input logic [19:0] t, input logic [15:0] h);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    start             <= 1'b1;
    raw_temperature_i <= t;
    raw_humidity_i    <= h;
    do @(posedge clk_i); while (busy);
    pairs_sent++;
    if (gap > 0) begin
      // Idle cycles carry junk on the sample ports.
      @(negedge clk_i);
      start             <= 1'b0;
      raw_temperature_i <= 20'($urandom);
      raw_humidity_i    <= 16'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [thc_pkg::CfgIdxW-1:0] idx,
                           input logic [thc_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 24'($urandom);
    repeat ($urandom_range(0, 3)) @(negedge clk_i);
  endtask

  task automatic load_cal(input thc_pkg::thc_cal_t c);
    drain();
    write_reg(thc_pkg::RegCalT1,   {8'b0, c.t1});
    write_reg(thc_pkg::RegCalT2,   {8'b0, c.t2});
    write_reg(thc_pkg::RegCalT3,   {8'b0, c.t3});
    write_reg(thc_pkg::RegCalH1,   {16'b0, c.h1});
    write_reg(thc_pkg::RegCalH2,   {8'b0, c.h2});
    write_reg(thc_pkg::RegCalH3,   {16'b0, c.h3});
    write_reg(thc_pkg::RegCalH4H5, c.h4_h5);
    write_reg(thc_pkg::RegCalH6,   {16'b0, c.h6});
    cal_sets++;
  endtask

  // Corners of both fields, the humidity clamps and alternating bit patterns.
  task automatic run_directed();
    push_sample(20'h00000, 16'h0000);
    push_sample(20'hFFFFF, 16'hFFFF);
    push_sample(20'h00000, 16'hFFFF);
    push_sample(20'hFFFFF, 16'h0000);
    push_sample(20'd519888, 16'd27010);
    push_sample(20'd519888, 16'h0000);
    push_sample(20'd519888, 16'hFFFF);
    push_sample(20'd415148, 16'd60000);
    push_sample(20'h80000, 16'h8000);
    push_sample(20'h7FFFF, 16'h7FFF);
    push_sample(20'h55555, 16'hAAAA);
    push_sample(20'hAAAAA, 16'h5555);
    push_sample(20'd80000, 16'd1);
  endtask

  task automatic run_random(input int n, input thc_pkg::thc_cal_t c);
    logic [19:0] t;
    logic [15:0] h;
    int          kind;
    for (int i = 0; i < n; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == n / 2 || $urandom_range(0, 99) == 0) drain();
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
        t = $urandom_range(0, 1) ? 20'hFFFFF : 20'h00000;
      end else if (kind < 4) begin
        // Near the operating point that the first trimming word implies.
        t = 20'(({4'b0, c.t1} << 4) + 20'($urandom_range(0, 131071)) - 20'd65536);
      end else begin
        t = 20'($urandom);
      end
      kind = $urandom_range(0, 7);
      if (kind == 0) h = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else           h = 16'($urandom);
      push_sample(t, h);
    end
    no_idle = 1'b0;
  endtask

  function automatic thc_pkg::thc_cal_t random_cal();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[111:0];
  endfunction

  initial begin
    thc_pkg::thc_cal_t typical_cal, high_cal, low_cal, ones_cal, rc;
    typical_cal = '{t1: 16'd27504, t2: 16'd26435, t3: 16'hFC18, h1: 8'd75, h2: 16'd362,
                    h3: 8'd0, h4_h5: {12'd313, 12'd50}, h6: 8'd30};
    high_cal    = '{t1: 16'hFFFF, t2: 16'h7FFF, t3: 16'h7FFF, h1: 8'hFF, h2: 16'h7FFF,
                    h3: 8'hFF, h4_h5: 24'h7FF7FF, h6: 8'h7F};
    low_cal     = '{t1: 16'h0000, t2: 16'h8000, t3: 16'h8000, h1: 8'h00, h2: 16'h8000,
                    h3: 8'h00, h4_h5: 24'h800800, h6: 8'h80};
    ones_cal    = '1;
    rst_ni            = 1'b0;
    start             = 1'b0;
    raw_temperature_i = '0;
    raw_humidity_i    = '0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    pairs_sent        = 0;
    cal_sets          = 1;
    no_idle           = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Trimming words still at their reset value of zero.
    run_directed();
    load_cal(typical_cal);
    run_directed();
    run_random(250, typical_cal);
    load_cal(high_cal);
    run_random(200, high_cal);
    load_cal(low_cal);
    run_random(200, low_cal);
    load_cal(ones_cal);
    run_random(200, ones_cal);
    load_cal('0);
    run_random(100, '0);
    repeat (4) begin
      rc = random_cal();
      load_cal(rc);
      run_random(250, rc);
    end

    drain();
    repeat (FlushCycles) @(posedge clk_i);
    $display("Sent %0d sample pairs under %0d trimming sets: zero, typical, extremes, random.",
             pairs_sent, cal_sets);
    $display("Compared %0d readings, %0d of them with humidity at a clamp limit.",
             readings, limit_hits);
    if (fail_count == 0 && outstanding == 0) begin
      $display("temp_humidity_compensation_unit: match");
    end else begin
      $display("temp_humidity_compensation_unit: mismatch");
    end
    $finish;
  end

endmodule
